### src/kphc_pkg.sv
// Package: shared widths, register codes and record types of the key press hold classifier.
`default_nettype none

package kphc_pkg;

  localparam int unsigned KEY_W = 4;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned FIRST_W = 15;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 3'd0,
    CFG_HOLD_FIRST = 3'd1,
    CFG_HOLD_INTERVAL = 3'd2,
    CFG_HOLD_SHORT = 3'd3,
    CFG_HOLD_LONG = 3'd4,
    CFG_IDLE_TIMEOUT = 3'd5
  } cfg_reg_e;

  // Reset values of the configuration registers
  localparam logic [CNT_W-1:0] RST_DEBOUNCE = 16'd1;
  localparam logic [FIRST_W-1:0] RST_HOLD_FIRST = 15'd25;
  localparam logic [FIRST_W-1:0] RST_HOLD_INTERVAL = 15'd25;
  localparam logic [CNT_W-1:0] RST_HOLD_SHORT = 16'd1;
  localparam logic [CNT_W-1:0] RST_HOLD_LONG = 16'd3;
  localparam logic [CNT_W-1:0] RST_IDLE_TIMEOUT = 16'd50;

  // Per-key state record held in the key memory
  typedef struct packed {
    logic             last;
    logic [CNT_W-1:0] press;
    logic [CNT_W-1:0] holds;
    logic [CNT_W-1:0] idle;
  } kphc_entry_t;

  // Event flags of one result item
  typedef struct packed {
    logic short_press;
    logic hold_repeat;
    logic hold_short;
    logic hold_long;
    logic idle_timeout;
  } kphc_flags_t;

endpackage

`default_nettype wire

### src/key_press_hold_classifier.sv
// Top level: per-key short press, hold repeat and idle timeout classifier over a key memory.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------------------
//  in      | sink      | in_valid_i / in_stall_o  | key_index_i, key_level_i
//  out     | source    | out_valid_o / out_stall_i| event_key_o, five event flags
//  cfg     | sink      | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// One item per cycle unless the output stalls; items pass stage 1, then the output register.
// Stage 0 reads the key memory (registered), stage 1 updates the entry and writes it back;
// a back-to-back item on the same key takes the just-written entry from a forwarding register.
// Reset clears control state and the per-key valid bits; an entry not yet written reads as zero.
// A stalled output holds stage 1, and in_stall_o rises only while both stages are full.
`default_nettype none

module key_press_hold_classifier #(
  parameter int unsigned KEY_COUNT = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [kphc_pkg::KEY_W-1:0]      key_index_i,
  input  wire logic                            key_level_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [kphc_pkg::KEY_W-1:0]      event_key_o,
  output logic                                 short_press_o,
  output logic                                 hold_repeat_o,
  output logic                                 hold_short_o,
  output logic                                 hold_long_o,
  output logic                                 idle_timeout_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [kphc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [kphc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import kphc_pkg::*;

  localparam int unsigned AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  // Configuration registers
  logic [CNT_W-1:0]   cfg_debounce_q, cfg_short_q, cfg_long_q, cfg_timeout_q;
  logic [FIRST_W-1:0] cfg_first_q, cfg_interval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_debounce_q <= RST_DEBOUNCE;
      cfg_first_q    <= RST_HOLD_FIRST;
      cfg_interval_q <= RST_HOLD_INTERVAL;
      cfg_short_q    <= RST_HOLD_SHORT;
      cfg_long_q     <= RST_HOLD_LONG;
      cfg_timeout_q  <= RST_IDLE_TIMEOUT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEBOUNCE:      cfg_debounce_q <= cfg_wdata_i;
        CFG_HOLD_FIRST:    cfg_first_q    <= cfg_wdata_i[FIRST_W-1:0];
        CFG_HOLD_INTERVAL: cfg_interval_q <= cfg_wdata_i[FIRST_W-1:0];
        CFG_HOLD_SHORT:    cfg_short_q    <= cfg_wdata_i;
        CFG_HOLD_LONG:     cfg_long_q     <= cfg_wdata_i;
        CFG_IDLE_TIMEOUT:  cfg_timeout_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake and stage control
  logic s1_vld_q, out_vld_q;
  logic s1_adv, in_acc, wr_en;

  assign s1_adv     = s1_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = s1_vld_q && out_vld_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  logic [AW-1:0] in_addr;
  logic          in_range;
  assign in_addr  = AW'(key_index_i);
  assign in_range = (int'(key_index_i) < int'(KEY_COUNT));

  // Stage 1 registers
  logic [KEY_W-1:0] s1_key_q;
  logic [AW-1:0]    s1_addr_q;
  logic             s1_lvl_q, s1_inr_q;
  logic             rd_vld_q, fwd_q;
  kphc_entry_t      rd_ent_q, fwd_ent_q, ent_d;

  assign wr_en = s1_adv && s1_inr_q;

  // Key memory and its valid bits
  kphc_entry_t          mem_q [KEY_COUNT];
  logic [KEY_COUNT-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[s1_addr_q] <= ent_d;
    end
    if (in_acc) begin
      rd_ent_q <= mem_q[in_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[s1_addr_q] <= 1'b1;
    end
  end

  // Advance stage 1; capture the forwarded entry when the same key follows directly
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_key_q  <= key_index_i;
      s1_addr_q <= in_addr;
      s1_lvl_q  <= key_level_i;
      s1_inr_q  <= in_range;
      rd_vld_q  <= valid_q[in_addr];
      fwd_q     <= wr_en && (s1_key_q == key_index_i);
      fwd_ent_q <= ent_d;
    end
  end

  // Update the key entry and raise the event flags
  kphc_entry_t      cur;
  kphc_flags_t      flags_d;
  logic [CNT_W-1:0] limit, first16, p1, h1, i1;

  assign cur     = fwd_q ? fwd_ent_q : (rd_vld_q ? rd_ent_q : '0);
  assign first16 = {1'b0, cfg_first_q};
  assign limit   = first16 + {1'b0, cfg_interval_q};
  assign p1      = sat_inc(cur.press);
  assign h1      = sat_inc(cur.holds);
  assign i1      = sat_inc(cur.idle);

  always_comb begin
    ent_d   = cur;
    flags_d = '0;
    if (s1_inr_q) begin
      ent_d.last = s1_lvl_q;
      if (s1_lvl_q && !cur.last) begin
        // rising edge: restart press and hold counts
        ent_d.press = '0;
        ent_d.holds = '0;
      end else if (s1_lvl_q) begin
        // held: count up, reload on each repeat
        ent_d.press = p1;
        if (p1 >= limit) begin
          ent_d.press         = first16;
          ent_d.holds         = h1;
          flags_d.hold_repeat = 1'b1;
        end
        if (ent_d.press == first16) begin
          flags_d.hold_short = (ent_d.holds == cfg_short_q);
          flags_d.hold_long  = (ent_d.holds == cfg_long_q);
        end
      end else if (cur.last) begin
        // falling edge: classify the press, clear all counts
        flags_d.short_press = (cur.press >= cfg_debounce_q) && (cur.press < limit) &&
                              (cur.holds == '0);
        ent_d.press = '0;
        ent_d.holds = '0;
        ent_d.idle  = '0;
      end else begin
        // released: count idle ticks, restart on timeout
        ent_d.idle = i1;
        if (i1 >= cfg_timeout_q) begin
          flags_d.idle_timeout = 1'b1;
          ent_d.idle           = '0;
        end
      end
    end
  end

  // Output register
  logic [KEY_W-1:0] out_key_q;
  kphc_flags_t      out_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_key_q   <= s1_key_q;
      out_flags_q <= flags_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign event_key_o    = out_key_q;
  assign short_press_o  = out_flags_q.short_press;
  assign hold_repeat_o  = out_flags_q.hold_repeat;
  assign hold_short_o   = out_flags_q.hold_short;
  assign hold_long_o    = out_flags_q.hold_long;
  assign idle_timeout_o = out_flags_q.idle_timeout;

endmodule

`default_nettype wire

### src/kphc_checker.sv
// Checker: port-level properties of the key press hold classifier, bound to the top level.
`default_nettype none

module kphc_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_stall_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic [kphc_pkg::KEY_W-1:0] event_key_o,
  input wire logic                       short_press_o,
  input wire logic                       hold_repeat_o,
  input wire logic                       hold_short_o,
  input wire logic                       hold_long_o,
  input wire logic                       idle_timeout_o
);
  import kphc_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_key_o))
    else $error("stalled result dropped or changed");

  // A short press comes only from a release, never with hold or idle events
  a_short_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && short_press_o |->
      !(hold_repeat_o || hold_short_o || hold_long_o || idle_timeout_o))
    else $error("short press flagged together with another event");

  // Idle timeout comes from a released key, never with hold events
  a_idle_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && idle_timeout_o |-> !(hold_repeat_o || hold_short_o || hold_long_o))
    else $error("idle timeout flagged together with a hold event");

  // A result after an empty output follows an accepted item that went through stage 1 unstalled
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result appeared without an accepted item");

endmodule

bind key_press_hold_classifier kphc_checker u_kphc_checker (.*);

`default_nettype wire

### tb/sv/tb_key_press_hold_classifier.sv
// Testbench: key press hold classifier checked against a per-key predictor.
`timescale 1ns / 100ps

module tb_key_press_hold_classifier;
  import kphc_pkg::*;

  localparam int unsigned KEYS = 16;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned HOLD_OFF_CYCLES = 64;
  localparam int unsigned PHASES = 10;
  localparam int unsigned PHASE_TICKS = 150;
  localparam int unsigned LONG_HOLD_TICKS = 170;
  // Index past the last register: writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  localparam kphc_flags_t FLAG_NONE = '0;
  localparam kphc_flags_t FLAG_SHORT = '{short_press: 1'b1, default: 1'b0};

  typedef enum logic {STEP_TICK, STEP_REG} step_kind_e;

  // One row of the directed plan: a scan tick or a register write
  typedef struct packed {
    step_kind_e  kind;
    logic [15:0] arg;
    logic [15:0] val;
    logic        typed;
    kphc_flags_t flags;
  } plan_step_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    kphc_flags_t      flags;
  } key_event_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [KEY_W-1:0] key_index_i = '0;
  logic key_level_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [KEY_W-1:0] event_key_o;
  logic short_press_o;
  logic hold_repeat_o;
  logic hold_short_o;
  logic hold_long_o;
  logic idle_timeout_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // Side flags that travel with the driven item
  logic item_typed = 1'b0;
  kphc_flags_t item_typed_flags = '0;

  logic calm = 1'b0;
  int unsigned hold_off_reqs = 0;
  int unsigned hold_off_seen = 0;
  int unsigned hold_off_left = 0;

  int unsigned ticks_sent = 0;
  int unsigned events_seen = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  key_event_t expected_events[$];

  // Predictor state and register copies
  logic        key_down [KEYS];
  logic [15:0] press_cnt [KEYS];
  logic [15:0] hold_cnt [KEYS];
  logic [15:0] idle_cnt [KEYS];
  logic [15:0] debounce_cfg;
  logic [14:0] first_cfg;
  logic [14:0] interval_cfg;
  logic [15:0] short_cfg;
  logic [15:0] long_cfg;
  logic [15:0] idle_cfg;

  plan_step_t directed_plan [0:36];

  key_press_hold_classifier #(
    .KEY_COUNT(KEYS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .key_index_i   (key_index_i),
    .key_level_i   (key_level_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_key_o   (event_key_o),
    .short_press_o (short_press_o),
    .hold_repeat_o (hold_repeat_o),
    .hold_short_o  (hold_short_o),
    .hold_long_o   (hold_long_o),
    .idle_timeout_o(idle_timeout_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Generate the clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [15:0] sat16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Advance one key's counters by one scan tick and return the flags it raises
  function automatic kphc_flags_t classify_tick(logic [KEY_W-1:0] key, logic lvl);
    kphc_flags_t f;
    logic [16:0] lim;
    f = '0;
    lim = first_cfg + interval_cfg;
    if (key < KEYS) begin
      if (lvl && !key_down[key]) begin
        press_cnt[key] = '0;
        hold_cnt[key] = '0;
      end else if (lvl) begin
        press_cnt[key] = sat16(press_cnt[key]);
        if (press_cnt[key] >= lim) begin
          press_cnt[key] = 16'(first_cfg);
          hold_cnt[key] = sat16(hold_cnt[key]);
          f.hold_repeat = 1'b1;
        end
        if (press_cnt[key] == first_cfg) begin
          f.hold_short = (hold_cnt[key] == short_cfg);
          f.hold_long = (hold_cnt[key] == long_cfg);
        end
      end else if (key_down[key]) begin
        f.short_press = (press_cnt[key] >= debounce_cfg) && (press_cnt[key] < lim) &&
                        (hold_cnt[key] == 16'd0);
        press_cnt[key] = '0;
        hold_cnt[key] = '0;
        idle_cnt[key] = '0;
      end else begin
        idle_cnt[key] = sat16(idle_cnt[key]);
        if (idle_cnt[key] >= idle_cfg) begin
          f.idle_timeout = 1'b1;
          idle_cnt[key] = '0;
        end
      end
      key_down[key] = lvl;
    end
    return f;
  endfunction

  task automatic report_bad(string why, key_event_t want, key_event_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%s: expected key %0d short %b repeat %b hold_short %b hold_long %b idle %b;",
                " got key %0d short %b repeat %b hold_short %b hold_long %b idle %b"},
               why, want.key, want.flags.short_press, want.flags.hold_repeat,
               want.flags.hold_short, want.flags.hold_long, want.flags.idle_timeout,
               got.key, got.flags.short_press, got.flags.hold_repeat,
               got.flags.hold_short, got.flags.hold_long, got.flags.idle_timeout);
  endtask

  // Predict on accepted items, check accepted results, apply register writes
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    key_event_t want;
    key_event_t got;
    if (!rst_ni) begin
      for (int k = 0; k < KEYS; k++) begin
        key_down[k] = 1'b0;
        press_cnt[k] = '0;
        hold_cnt[k] = '0;
        idle_cnt[k] = '0;
      end
      debounce_cfg = RST_DEBOUNCE;
      first_cfg = RST_HOLD_FIRST;
      interval_cfg = RST_HOLD_INTERVAL;
      short_cfg = RST_HOLD_SHORT;
      long_cfg = RST_HOLD_LONG;
      idle_cfg = RST_IDLE_TIMEOUT;
      quiet_cycles = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_DEBOUNCE:      debounce_cfg = cfg_wdata_i;
          CFG_HOLD_FIRST:    first_cfg = cfg_wdata_i[FIRST_W-1:0];
          CFG_HOLD_INTERVAL: interval_cfg = cfg_wdata_i[FIRST_W-1:0];
          CFG_HOLD_SHORT:    short_cfg = cfg_wdata_i;
          CFG_HOLD_LONG:     long_cfg = cfg_wdata_i;
          CFG_IDLE_TIMEOUT:  idle_cfg = cfg_wdata_i;
          default: ;
        endcase
      end
      // Check the oldest expectation first
      if (out_valid_o && !out_stall_i) begin
        events_seen++;
        got.key = event_key_o;
        got.flags = '{short_press_o, hold_repeat_o, hold_short_o, hold_long_o, idle_timeout_o};
        if (expected_events.size() == 0) begin
          report_bad("unexpected result", '0, got);
        end else begin
          want = expected_events.pop_front();
          if (got !== want) report_bad("mismatch", want, got);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        want.key = key_index_i;
        want.flags = classify_tick(key_index_i, key_level_i);
        if (item_typed) want.flags = item_typed_flags;
        expected_events.push_back(want);
      end
      // Watchdog on handshake progress
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_off_seen != hold_off_reqs) begin
      hold_off_seen <= hold_off_reqs;
      hold_off_left <= HOLD_OFF_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(0, 99) < 8);
    end
  end

  // Drop valid and wait until every expected result has arrived
  task automatic drain();
    in_valid_i <= 1'b0;
    cfg_we_i <= 1'b0;
    while (events_seen != ticks_sent) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Offer one scan tick after a random gap and hold it until accepted
  task automatic send_tick(logic [KEY_W-1:0] key, logic lvl, logic typed, kphc_flags_t flags);
    cfg_we_i <= 1'b0;
    while (!calm && $urandom_range(0, 99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    key_index_i <= key;
    key_level_i <= lvl;
    item_typed <= typed;
    item_typed_flags <= flags;
    do @(posedge clk_i); while (in_stall_o);
    ticks_sent++;
  endtask

  initial begin : stimulus
    plan_step_t step;
    logic [15:0] v_deb, v_first, v_int, v_short, v_long, v_idle;
    logic [KEY_W-1:0] pool [4];
    logic run_level [KEYS];
    int unsigned run_left [KEYS];
    int unsigned pool_n, k, lim, reps, cap;

    directed_plan = '{
      // reset settings: readable at a glance
      '{STEP_TICK, 16'd0, 16'd0, 1'b1, FLAG_NONE},
      '{STEP_TICK, 16'd15, 16'd1, 1'b1, FLAG_NONE},
      '{STEP_TICK, 16'd15, 16'd1, 1'b1, FLAG_NONE},
      '{STEP_TICK, 16'd15, 16'd0, 1'b1, FLAG_SHORT},
      '{STEP_TICK, 16'd3, 16'd1, 1'b1, FLAG_NONE},
      '{STEP_TICK, 16'd3, 16'd0, 1'b1, FLAG_NONE},
      // zero interval, zero timeout, zero short repeat setting
      '{STEP_REG, 16'(CFG_DEBOUNCE), 16'd0, 1'b0, FLAG_NONE},
      '{STEP_REG, 16'(CFG_HOLD_FIRST), 16'd0, 1'b0, FLAG_NONE},
      '{STEP_REG, 16'(CFG_HOLD_INTERVAL), 16'd0, 1'b0, FLAG_NONE},
      '{STEP_REG, 16'(CFG_HOLD_SHORT), 16'd0, 1'b0, FLAG_NONE},
      '{STEP_REG, 16'(CFG_HOLD_LONG), 16'd2, 1'b0, FLAG_NONE},
      '{STEP_REG, 16'(CFG_IDLE_TIMEOUT), 16'd0, 1'b0, FLAG_NONE},
      '{STEP_TICK, 16'd5, 16'd1, 1'b0, FLAG_NONE},
      '{STEP_TICK, 16'd5, 16'd1, 1'b0, FLAG_NONE},
      '{STEP_TICK, 16'd5, 16'd1, 1'b0, FLAG_NONE},
      '{STEP_TICK, 16'd5, 16'd0, 1'b0, FLAG_NONE},
      '{STEP_TICK, 16'd5, 16'd0, 1'b0, FLAG_NONE},
      '{STEP_TICK, 16'd5, 16'd0, 1'b0, FLAG_NONE},
      '{STEP_TICK, 16'd6, 16'd1, 1'b0, FLAG_NONE},
      '{STEP_TICK, 16'd6, 16'd0, 1'b0, FLAG_NONE},
      // hold events before any repeat
      '{STEP_REG, 16'(CFG_HOLD_FIRST), 16'd2, 1'b0, FLAG_NONE},
      '{STEP_REG, 16'(CFG_HOLD_INTERVAL), 16'd1, 1'b0, FLAG_NONE},
      '{STEP_REG, 16'(CFG_HOLD_LONG), 16'd0, 1'b0, FLAG_NONE},
      '{STEP_TICK, 16'd7, 16'd1, 1'b0, FLAG_NONE},
      '{STEP_TICK, 16'd7, 16'd1, 1'b0, FLAG_NONE},
      '{STEP_TICK, 16'd7, 16'd1, 1'b0, FLAG_NONE},
      '{STEP_TICK, 16'd7, 16'd1, 1'b0, FLAG_NONE},
      '{STEP_TICK, 16'd7, 16'd0, 1'b0, FLAG_NONE},
      // ignored index, widths masked, largest settings
      '{STEP_REG, 16'(CFG_SPARE), 16'hFFFF, 1'b0, FLAG_NONE},
      '{STEP_REG, 16'(CFG_DEBOUNCE), 16'hFFFF, 1'b0, FLAG_NONE},
      '{STEP_REG, 16'(CFG_HOLD_FIRST), 16'hFFFF, 1'b0, FLAG_NONE},
      '{STEP_REG, 16'(CFG_HOLD_INTERVAL), 16'hFFFF, 1'b0, FLAG_NONE},
      '{STEP_REG, 16'(CFG_IDLE_TIMEOUT), 16'hFFFF, 1'b0, FLAG_NONE},
      '{STEP_TICK, 16'd8, 16'd1, 1'b0, FLAG_NONE},
      '{STEP_TICK, 16'd8, 16'd1, 1'b0, FLAG_NONE},
      '{STEP_TICK, 16'd8, 16'd0, 1'b0, FLAG_NONE},
      '{STEP_TICK, 16'd8, 16'd0, 1'b0, FLAG_NONE}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed plan
    foreach (directed_plan[i]) begin
      step = directed_plan[i];
      if (step.kind == STEP_REG) write_reg(step.arg[CFG_IDX_W-1:0], step.val);
      else send_tick(step.arg[KEY_W-1:0], step.val[0], step.typed, step.flags);
    end

    for (int r = 0; r < KEYS; r++) begin
      run_level[r] = 1'b0;
      run_left[r] = 0;
    end

    // Random phases, each under its own settings
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          v_deb = RST_DEBOUNCE;
          v_first = 16'(RST_HOLD_FIRST);
          v_int = 16'(RST_HOLD_INTERVAL);
          v_short = RST_HOLD_SHORT;
          v_long = RST_HOLD_LONG;
          v_idle = RST_IDLE_TIMEOUT;
        end
        1: begin
          v_deb = '0; v_first = '0; v_int = '0;
          v_short = '0; v_long = '0; v_idle = '0;
        end
        2: begin
          v_deb = '1; v_first = '1; v_int = '1;
          v_short = '1; v_long = '1; v_idle = '1;
        end
        default: begin
          v_deb = 16'($urandom_range(0, 6));
          v_first = 16'($urandom_range(0, 6));
          v_int = 16'($urandom_range(0, 6));
          v_short = 16'($urandom_range(0, 4));
          v_long = 16'($urandom_range(0, 6));
          v_idle = 16'($urandom_range(0, 12));
        end
      endcase
      write_reg(CFG_DEBOUNCE, v_deb);
      write_reg(CFG_HOLD_FIRST, v_first);
      write_reg(CFG_HOLD_INTERVAL, v_int);
      write_reg(CFG_HOLD_SHORT, v_short);
      write_reg(CFG_HOLD_LONG, v_long);
      write_reg(CFG_IDLE_TIMEOUT, v_idle);
      if ($urandom_range(0, 1)) write_reg(CFG_SPARE, 16'($urandom));
      calm <= (p == 3);

      lim = int'(v_first[FIRST_W-1:0]) + int'(v_int[FIRST_W-1:0]);
      reps = (v_short > v_long) ? v_short : v_long;
      if (reps > 8) reps = 8;
      pool_n = $urandom_range(1, 4);
      for (int j = 0; j < 4; j++) pool[j] = KEY_W'($urandom_range(0, KEYS - 1));

      for (int n = 0; n < PHASE_TICKS; n++) begin
        if ((p == 4 || p == 7) && n == 40) hold_off_reqs <= hold_off_reqs + 1;
        if (p == 5 && n == 75) drain();
        if ($urandom_range(0, 9) == 0) begin
          // noise: any key, any level
          send_tick(KEY_W'($urandom_range(0, KEYS - 1)), 1'($urandom_range(0, 1)), 1'b0,
                    FLAG_NONE);
        end else begin
          k = pool[$urandom_range(0, pool_n - 1)];
          if (run_left[k] == 0) begin
            run_level[k] = !run_level[k];
            if (!run_level[k]) cap = int'(v_idle) * 3 + 2;
            else if ($urandom_range(0, 1)) cap = int'(v_deb) + lim + 2;
            else cap = lim * (reps + 2) + 2;
            if (cap > 300) cap = 300;
            run_left[k] = $urandom_range(1, cap);
          end
          run_left[k]--;
          send_tick(KEY_W'(k), run_level[k], 1'b0, FLAG_NONE);
        end
      end
    end

    // Hold one key through a long run of back-to-back hold repeats
    calm <= 1'b0;
    write_reg(CFG_DEBOUNCE, 16'd0);
    write_reg(CFG_HOLD_FIRST, 16'd0);
    write_reg(CFG_HOLD_INTERVAL, 16'd0);
    write_reg(CFG_HOLD_SHORT, 16'hFFFF);
    write_reg(CFG_HOLD_LONG, 16'hFFFE);
    write_reg(CFG_IDLE_TIMEOUT, 16'd1);
    repeat (LONG_HOLD_TICKS) send_tick(4'd9, 1'b1, 1'b0, FLAG_NONE);
    repeat (2) send_tick(4'd9, 1'b0, 1'b0, FLAG_NONE);

    drain();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
